// ===== rtl/core/bdq_pkg.sv =====
// Shared types and constants for the bounded double-ended queue core.
package bdq_pkg;

    localparam int DEPTH_DEF  = 1024;
    localparam int DATA_W_DEF = 16;

    localparam int ACTION_W = 3;
    localparam int CAP_W    = 11;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // Operation codes; unused codes behave as a query.
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_REAR  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_REAR   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_QUERY      = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } bdq_state_t;

endpackage

// ===== rtl/core/bounded_double_ended_queue_core.sv =====
// Bounded double-ended queue: ring buffer in one memory with front/rear indices.
//
// Usage:
//   Input channel (s_valid/s_ready): one operation per transfer, s_action
//   selects push front, push rear, pop front, pop rear or query; s_value is
//   the word pushed. Result channel (m_valid/m_ready): one result per
//   operation with ok, front/rear words and valid flags, empty and full,
//   all as they stand after the operation.
//   Config: cfg_we/cfg_wdata write the capacity (0 acts as 1, above DEPTH
//   acts as DEPTH). Write it only while no operation is in flight.
// Sequence:
//   An operation moves through IDLE, READ and LOAD: the transfer cycle in
//   IDLE updates indices and count and writes a pushed word, READ reads the
//   front and rear entries from the memory into registers, and LOAD moves
//   them into the result register. s_ready is high only in IDLE, so a new
//   operation is taken only after the last one has been loaded.
// Reset: synchronous active-low aresetn empties the deque and restores
//   capacity to 1024; memory contents are not cleared.
// Stall: the result register holds while m_ready is low; a new operation
//   may still be taken and read, it then waits until the result drains.
module bounded_double_ended_queue_core #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_W_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_we,
    input  logic [bdq_pkg::CAP_W-1:0]     cfg_wdata,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bdq_pkg::ACTION_W-1:0]  s_action,
    input  logic [DATA_WIDTH-1:0]         s_value,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_ok,
    output logic [DATA_WIDTH-1:0]         m_front_value,
    output logic                          m_front_valid,
    output logic [DATA_WIDTH-1:0]         m_rear_value,
    output logic                          m_rear_valid,
    output logic                          m_is_empty,
    output logic                          m_is_full
);

    import bdq_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    // Clamp a written capacity into 1..DEPTH.
    function automatic logic [CNT_W-1:0] clamp_cap(input logic [CAP_W-1:0] c);
        logic [CMP_W-1:0] c_ext;
        c_ext = CMP_W'(c);
        if (c == '0) begin
            return CNT_W'(1);
        end else if (c_ext > CMP_W'(DEPTH)) begin
            return CNT_W'(DEPTH);
        end else begin
            return CNT_W'(c_ext);
        end
    endfunction

    function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] i);
        return (i == LAST_SLOT) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] i);
        return (i == '0) ? LAST_SLOT : i - AW'(1);
    endfunction

    // Entry store
    logic [DATA_WIDTH-1:0] mem [DEPTH];

    // Control state
    bdq_state_t       state_reg, state_next;
    logic [AW-1:0]    front_idx_reg, front_idx_next;
    logic [AW-1:0]    rear_idx_reg, rear_idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cap_live_reg;

    // Flags of the operation in flight
    logic             ok_reg, ok_next;
    logic             empty_reg, empty_next;
    logic             full_reg, full_next;

    // Memory read data
    logic [DATA_WIDTH-1:0] rd_front_reg;
    logic [DATA_WIDTH-1:0] rd_rear_reg;

    // Result register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_ok_reg;
    logic [DATA_WIDTH-1:0] out_front_reg;
    logic [DATA_WIDTH-1:0] out_rear_reg;
    logic                  out_empty_reg;
    logic                  out_full_reg;

    logic                  in_xfer;
    logic                  load_fire;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic                  cur_full;
    logic                  cur_empty;

    assign in_xfer   = s_valid && s_ready;
    assign cur_full  = cnt_reg >= cap_live_reg;
    assign cur_empty = cnt_reg == '0;

    // Index/count update for the operation being transferred in.
    always_comb begin
        front_idx_next = front_idx_reg;
        rear_idx_next  = rear_idx_reg;
        cnt_next       = cnt_reg;
        ok_next        = ok_reg;
        empty_next     = empty_reg;
        full_next      = full_reg;
        wr_en          = 1'b0;
        wr_addr        = rear_idx_reg;
        if (in_xfer) begin
            ok_next = 1'b1;
            unique case (s_action)
                ACT_PUSH_FRONT: begin
                    if (cur_full) begin
                        ok_next = 1'b0;
                    end else begin
                        front_idx_next = slot_prev(front_idx_reg);
                        wr_en          = 1'b1;
                        wr_addr        = slot_prev(front_idx_reg);
                        cnt_next       = cnt_reg + CNT_W'(1);
                    end
                end
                ACT_PUSH_REAR: begin
                    if (cur_full) begin
                        ok_next = 1'b0;
                    end else begin
                        wr_en         = 1'b1;
                        wr_addr       = rear_idx_reg;
                        rear_idx_next = slot_next(rear_idx_reg);
                        cnt_next      = cnt_reg + CNT_W'(1);
                    end
                end
                ACT_POP_FRONT: begin
                    if (cur_empty) begin
                        ok_next = 1'b0;
                    end else begin
                        front_idx_next = slot_next(front_idx_reg);
                        cnt_next       = cnt_reg - CNT_W'(1);
                    end
                end
                ACT_POP_REAR: begin
                    if (cur_empty) begin
                        ok_next = 1'b0;
                    end else begin
                        rear_idx_next = slot_prev(rear_idx_reg);
                        cnt_next      = cnt_reg - CNT_W'(1);
                    end
                end
                default: begin
                    // query and unused codes: no change
                end
            endcase
            empty_next = cnt_next == '0;
            full_next  = cnt_next >= cap_live_reg;
        end
    end

    // Sequencer: accept, read memory, move into result register.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        load_fire  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                // wait for the result register to drain
                if (!out_valid_reg || m_ready) begin
                    load_fire  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            front_idx_reg <= '0;
            rear_idx_reg  <= '0;
            cnt_reg       <= '0;
            cap_live_reg  <= clamp_cap(CAP_RESET);
            ok_reg        <= 1'b0;
            empty_reg     <= 1'b1;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            front_idx_reg <= front_idx_next;
            rear_idx_reg  <= rear_idx_next;
            cnt_reg       <= cnt_next;
            ok_reg        <= ok_next;
            empty_reg     <= empty_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                cap_live_reg <= clamp_cap(cfg_wdata);
            end
        end
    end

    // Memory: write on push transfer, read front and last rear slot in READ.
    // A write and the following reads never share a cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_value;
        end
        if (state_reg == ST_READ) begin
            rd_front_reg <= mem[front_idx_reg];
            rd_rear_reg  <= mem[slot_prev(rear_idx_reg)];
        end
    end

    // Result payload; empty deque reports zero words.
    always_ff @(posedge aclk) begin
        if (load_fire) begin
            out_ok_reg    <= ok_reg;
            out_empty_reg <= empty_reg;
            out_full_reg  <= full_reg;
            out_front_reg <= empty_reg ? '0 : rd_front_reg;
            out_rear_reg  <= empty_reg ? '0 : rd_rear_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_ok          = out_ok_reg;
    assign m_front_value = out_front_reg;
    assign m_front_valid = !out_empty_reg;
    assign m_rear_value  = out_rear_reg;
    assign m_rear_valid  = !out_empty_reg;
    assign m_is_empty    = out_empty_reg;
    assign m_is_full     = out_full_reg;

    // Checks

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_empty_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (front_idx_reg == rear_idx_reg))
        else $error("empty deque with diverged indices");

    a_xfer_read: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (state_reg == ST_READ))
        else $error("transfer not followed by memory read");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> !load_fire || m_ready || $past(m_ready))
        else $error("result register overwritten while stalled");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the bounded double-ended queue core.
module tb_top;
    import bdq_pkg::*;

    localparam int DW    = DATA_W_DEF;
    localparam int SLOTS = DEPTH_DEF;
    localparam int AW    = $clog2(DEPTH_DEF);

    // Codes above the query code; the core treats them as a query.
    localparam logic [ACTION_W-1:0] ACT_SPARE_5 = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    // Keep the log readable if the core is badly broken.
    localparam int MAX_REPORTS = 200;

    // One result transfer as the core should present it.
    typedef struct {
        logic          ok;
        logic [DW-1:0] front_value;
        logic          front_valid;
        logic [DW-1:0] rear_value;
        logic          rear_valid;
        logic          is_empty;
        logic          is_full;
    } deque_view_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CAP_W-1:0]    cfg_wdata = '0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic [ACTION_W-1:0] s_action  = '0;
    logic [DW-1:0]       s_value   = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic                m_ok;
    logic [DW-1:0]       m_front_value;
    logic                m_front_valid;
    logic [DW-1:0]       m_rear_value;
    logic                m_rear_valid;
    logic                m_is_empty;
    logic                m_is_full;

    bounded_double_ended_queue_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_front_value (m_front_value),
        .m_front_valid (m_front_valid),
        .m_rear_value  (m_rear_value),
        .m_rear_valid  (m_rear_valid),
        .m_is_empty    (m_is_empty),
        .m_is_full     (m_is_full)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Deque predictor: its own ring, indices, count and capacity.
    // head_slot points at the front entry, tail_slot one past the rear.
    // ------------------------------------------------------------------
    bit   [DW-1:0]    ring_word [SLOTS];
    logic [AW-1:0]    head_slot = '0;
    logic [AW-1:0]    tail_slot = '0;
    int unsigned      held      = 0;
    logic [CAP_W-1:0] cap_reg   = CAP_RESET;

    deque_view_t      pending[$];      // results still owed by the core
    int unsigned      mismatch_count = 0;
    bit               no_gaps = 1'b0;  // both sides run flat out when set

    // Zero behaves as one, anything above the ring size as the ring size.
    function automatic int unsigned cap_limit();
        if (cap_reg == '0)
            return 1;
        if (cap_reg > SLOTS)
            return SLOTS;
        return 32'(cap_reg);
    endfunction

    function automatic deque_view_t apply_op(logic [ACTION_W-1:0] act, logic [DW-1:0] word);
        deque_view_t   v;
        logic          was_full;
        logic          was_empty;
        logic [AW-1:0] last_slot;
        was_full  = held >= cap_limit();
        was_empty = held == 0;
        v.ok      = 1'b1;
        case (act)
            ACT_PUSH_FRONT: begin
                if (was_full) begin
                    v.ok = 1'b0;
                end else begin
                    head_slot = head_slot - AW'(1);
                    ring_word[head_slot] = word;
                    held++;
                end
            end
            ACT_PUSH_REAR: begin
                if (was_full) begin
                    v.ok = 1'b0;
                end else begin
                    ring_word[tail_slot] = word;
                    tail_slot = tail_slot + AW'(1);
                    held++;
                end
            end
            ACT_POP_FRONT: begin
                if (was_empty) begin
                    v.ok = 1'b0;
                end else begin
                    head_slot = head_slot + AW'(1);
                    held--;
                end
            end
            ACT_POP_REAR: begin
                if (was_empty) begin
                    v.ok = 1'b0;
                end else begin
                    tail_slot = tail_slot - AW'(1);
                    held--;
                end
            end
            default: ;  // query and spare codes leave the deque alone
        endcase
        v.is_empty = held == 0;
        v.is_full  = held >= cap_limit();
        last_slot  = tail_slot - AW'(1);
        if (v.is_empty) begin
            v.front_value = '0;
            v.front_valid = 1'b0;
            v.rear_value  = '0;
            v.rear_valid  = 1'b0;
        end else begin
            v.front_value = ring_word[head_slot];
            v.front_valid = 1'b1;
            v.rear_value  = ring_word[last_slot];
            v.rear_valid  = 1'b1;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    // Mostly back to back, often a short pause, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DW-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return DW'($urandom);
        endcase
    endfunction

    // push_pct percent pushes; the rest is mostly pops with a few queries.
    function automatic logic [ACTION_W-1:0] pick_action(int unsigned push_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
        r = $urandom_range(0, 19);
        if (r < 8)
            return ACT_POP_FRONT;
        if (r < 16)
            return ACT_POP_REAR;
        if (r < 18)
            return ACT_QUERY;
        if (r == 18)
            return $urandom_range(0, 1) ? ACT_SPARE_5 : ACT_SPARE_6;
        return ACT_SPARE_7;
    endfunction

    // ------------------------------------------------------------------
    // Input side. Called at a rising edge; returns at the edge where the
    // transfer happened, with s_valid still high so a back-to-back item
    // needs no second assignment in the same step.
    // ------------------------------------------------------------------
    task automatic send_op(input logic [ACTION_W-1:0] act, input logic [DW-1:0] word);
        int unsigned gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_value  <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending.push_back(apply_op(act, word));
    endtask

    // Stop sending and wait until every owed result has been taken.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
    endtask

    // Only called with the core idle.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge aclk);
        cap_reg = cap;
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure on m_ready.
    // ------------------------------------------------------------------
    int unsigned ready_left = 0;

    always @(posedge aclk) begin : result_sink
        int unsigned stall;
        if (ready_left != 0) begin
            ready_left = ready_left - 1;
        end else begin
            stall = no_gaps ? 0 : pick_gap();
            if (stall == 0) begin
                m_ready <= 1'b1;
                ready_left = $urandom_range(0, 7);
            end else begin
                m_ready <= 1'b0;
                ready_left = stall - 1;
            end
        end
    end

    function automatic void check_field(string label, logic [DW-1:0] want, logic [DW-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t %s: expected %h actual %h", $time, label, want, got);
        end
    endfunction

    // Every result transfer is matched against the oldest owed result.
    always @(posedge aclk) begin : result_check
        deque_view_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t unexpected result: expected none actual ok=%b", $time, m_ok);
            end else begin
                want = pending.pop_front();
                check_field("ok",          DW'(want.ok),          DW'(m_ok));
                check_field("front_value", want.front_value,      m_front_value);
                check_field("front_valid", DW'(want.front_valid), DW'(m_front_valid));
                check_field("rear_value",  want.rear_value,       m_rear_value);
                check_field("rear_valid",  DW'(want.rear_valid),  DW'(m_rear_valid));
                check_field("is_empty",    DW'(want.is_empty),    DW'(m_is_empty));
                check_field("is_full",     DW'(want.is_full),     DW'(m_is_full));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Fresh deque: queries and refused pops, including the spare codes.
    task automatic test_empty_deque();
        send_op(ACT_QUERY, 16'h0000);
        send_op(ACT_POP_FRONT, 16'hFFFF);
        send_op(ACT_POP_REAR, 16'hFFFF);
        send_op(ACT_SPARE_5, 16'hAAAA);
        send_op(ACT_SPARE_6, 16'h5555);
        send_op(ACT_SPARE_7, 16'hFFFF);
    endtask

    // Capacity zero acts as one: front and rear are the same single entry.
    task automatic test_single_slot();
        drain_results();
        set_capacity('0);
        send_op(ACT_PUSH_REAR, 16'hFFFF);
        send_op(ACT_PUSH_FRONT, 16'h1234);   // refused, full
        send_op(ACT_POP_FRONT, 16'h0000);
        send_op(ACT_PUSH_FRONT, 16'h0000);
        send_op(ACT_PUSH_REAR, 16'hAAAA);    // refused, full
        send_op(ACT_QUERY, 16'h5555);
        send_op(ACT_POP_REAR, 16'h0000);
        drain_results();
        set_capacity(11'd1);
        send_op(ACT_PUSH_FRONT, 16'h5555);
        send_op(ACT_POP_FRONT, 16'h0000);
    endtask

    // Shrinking the capacity below the current count: the deque reads as
    // full, pushes are refused, and pops still work, down to empty.
    task automatic test_shrink_loaded();
        drain_results();
        set_capacity(11'd4);
        send_op(ACT_PUSH_FRONT, 16'hAAAA);
        send_op(ACT_PUSH_REAR, 16'h5555);
        send_op(ACT_PUSH_FRONT, 16'h0001);
        send_op(ACT_PUSH_REAR, 16'h8000);
        send_op(ACT_PUSH_REAR, 16'hFFFF);    // refused, full
        drain_results();
        set_capacity(11'd2);
        send_op(ACT_PUSH_FRONT, 16'h7777);   // refused, over capacity
        send_op(ACT_POP_FRONT, 16'h0000);
        send_op(ACT_POP_REAR, 16'h0000);
        send_op(ACT_POP_FRONT, 16'h0000);
        send_op(ACT_POP_REAR, 16'h0000);
    endtask

    task automatic run_mix(input logic [CAP_W-1:0] cap, input int unsigned n,
                           input int unsigned push_pct, input bit steady);
        drain_results();
        set_capacity(cap);
        no_gaps = steady;
        repeat (n) send_op(pick_action(push_pct), pick_word());
        drain_results();
        no_gaps = 1'b0;
    endtask

    // Random traffic over several capacities; small ones keep the deque
    // bouncing between empty and full, and the indices wrap around the ring.
    task automatic test_random_mix();
        run_mix(11'd3,    100, 50, 1'b0);
        run_mix(11'd17,   150, 55, 1'b0);
        run_mix(11'd1,     60, 50, 1'b1);
        run_mix(11'd2047,  80, 50, 1'b0);   // above the ring size
        run_mix(11'd1025,  60, 50, 1'b1);
    endtask

    // Full ring: fill to the largest capacity, then mixed traffic at the top.
    task automatic test_fill_to_depth();
        drain_results();
        set_capacity(CAP_RESET);
        while (held < cap_limit()) begin
            if ($urandom_range(0, 15) == 0)
                send_op(ACT_QUERY, pick_word());
            else
                send_op($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR, pick_word());
        end
        repeat (40) send_op(pick_action(60), pick_word());
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_deque();
        test_single_slot();
        test_shrink_loaded();
        test_random_mix();
        test_fill_to_depth();

        drain_results();
        // keep running to catch any stray result transfer
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Watchdog, well past the slowest legal run.
    initial begin
        #3000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
